[rtl/kcx_pkg.sv]
package kcx_pkg;

  // Cipher state and round unit geometry.
  localparam int unsigned STATE_BITS  = 288;
  localparam int unsigned KEY_BITS    = 128;
  localparam int unsigned REG_A_BITS  = 93;
  localparam int unsigned REG_B_BITS  = 84;
  localparam int unsigned REG_C_BITS  = 111;
  localparam int unsigned REG_B_START = 93;
  localparam int unsigned REG_C_START = 177;
  localparam int unsigned ONES_START  = 221;
  localparam int unsigned STEP_ROUNDS = 64;
  localparam int unsigned STEP_W      = 7;

  // Feedback taps, numbered as state bits with bit 0 at the head of register A.
  localparam int unsigned TAP_A_OUT0 = 65;
  localparam int unsigned TAP_A_OUT1 = 92;
  localparam int unsigned TAP_A_AND0 = 90;
  localparam int unsigned TAP_A_AND1 = 91;
  localparam int unsigned TAP_A_FB   = 170;
  localparam int unsigned TAP_B_OUT0 = 161;
  localparam int unsigned TAP_B_OUT1 = 176;
  localparam int unsigned TAP_B_AND0 = 174;
  localparam int unsigned TAP_B_AND1 = 175;
  localparam int unsigned TAP_B_FB   = 263;
  localparam int unsigned TAP_C_OUT0 = 242;
  localparam int unsigned TAP_C_OUT1 = 287;
  localparam int unsigned TAP_C_AND0 = 285;
  localparam int unsigned TAP_C_AND1 = 286;
  localparam int unsigned TAP_C_FB   = 68;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] IV_HIGH_RST = 64'h1111_1111_1111_1111;
  localparam logic [CFG_W-1:0] IV_LOW_RST  = 64'h1111_1111_1111_1110;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WARM = 3'b010,
    ST_KSTR = 3'b100
  } state_e;

  // Everything the round unit advances: the shift registers and the two
  // rotating 128-bit registers. Bit 0 of the key and IV sits at [127].
  typedef struct packed {
    logic [STATE_BITS-1:0] st;
    logic [KEY_BITS-1:0]   key;
    logic [KEY_BITS-1:0]   iv;
  } kcx_core_t;

endpackage

[rtl/kcx_round_unit.sv]
module kcx_round_unit import kcx_pkg::*; (
  input  kcx_core_t               cur_i,
  input  logic [STEP_W-1:0]       step_i,
  output kcx_core_t               nxt_o,
  output logic [STEP_ROUNDS-1:0]  ks_o
);

  logic [STEP_ROUNDS-1:0]             new_a;
  logic [STEP_ROUNDS-1:0]             new_b;
  logic [STEP_ROUNDS-1:0]             new_c;
  logic [REG_A_BITS+STEP_ROUNDS-1:0]  ext_a;
  logic [REG_B_BITS+STEP_ROUNDS-1:0]  ext_b;
  logic [REG_C_BITS+STEP_ROUNDS-1:0]  ext_c;
  logic [2*KEY_BITS-1:0]              key_dbl;
  logic [2*KEY_BITS-1:0]              iv_dbl;
  logic [STEP_W-1:0]                  shift;
  logic [STEP_W:0]                    rot_base;

  // All rounds of one step read only bits of the starting state, since the
  // nearest tap lies more than a full step behind each insertion point.
  always_comb begin
    logic ta, tb, tc, kb, vb;
    new_a = '0;
    new_b = '0;
    new_c = '0;
    ks_o  = '0;
    for (int t = 0; t < STEP_ROUNDS; t++) begin
      kb = cur_i.key[KEY_BITS-1-t];
      vb = cur_i.iv[KEY_BITS-1-t];
      ta = cur_i.st[TAP_A_OUT0-t] ^ cur_i.st[TAP_A_OUT1-t];
      tb = cur_i.st[TAP_B_OUT0-t] ^ cur_i.st[TAP_B_OUT1-t];
      tc = cur_i.st[TAP_C_OUT0-t] ^ cur_i.st[TAP_C_OUT1-t] ^ kb;
      ks_o[STEP_ROUNDS-1-t] = ta ^ tb ^ tc;
      new_b[STEP_ROUNDS-1-t] = ta ^ (cur_i.st[TAP_A_AND0-t] & cur_i.st[TAP_A_AND1-t])
                               ^ cur_i.st[TAP_A_FB-t] ^ vb;
      new_c[STEP_ROUNDS-1-t] = tb ^ (cur_i.st[TAP_B_AND0-t] & cur_i.st[TAP_B_AND1-t])
                               ^ cur_i.st[TAP_B_FB-t];
      new_a[STEP_ROUNDS-1-t] = tc ^ (cur_i.st[TAP_C_AND0-t] & cur_i.st[TAP_C_AND1-t])
                               ^ cur_i.st[TAP_C_FB-t];
    end
  end

  // Advance each register by the step count: the oldest fresh bits land
  // deepest, the register contents move up by the same amount.
  assign shift    = STEP_W'(STEP_ROUNDS) - step_i;
  assign ext_a    = {cur_i.st[REG_A_BITS-1:0], new_a};
  assign ext_b    = {cur_i.st[REG_C_START-1:REG_B_START], new_b};
  assign ext_c    = {cur_i.st[STATE_BITS-1:REG_C_START], new_c};

  assign nxt_o.st = {ext_c[shift +: REG_C_BITS],
                     ext_b[shift +: REG_B_BITS],
                     ext_a[shift +: REG_A_BITS]};

  // Key and IV rotate by the step count so bit 0 is always the next round's bit.
  assign rot_base   = (STEP_W+1)'(KEY_BITS) - {1'b0, step_i};
  assign key_dbl    = {cur_i.key, cur_i.key};
  assign iv_dbl     = {cur_i.iv, cur_i.iv};
  assign nxt_o.key  = key_dbl[rot_base +: KEY_BITS];
  assign nxt_o.iv   = iv_dbl[rot_base +: KEY_BITS];

endmodule

[rtl/kreyvium_ctr_keystream_xor.sv]
// Kreyvium keystream XOR in counter mode. Each request carries a 64-bit block
// counter and one data block; the result is the block XORed with the keystream
// produced from the configured key and the base IV with the counter XORed into
// its last 64 bits. A single round unit advances the cipher by up to 64 rounds
// per clock during warm-up, in full steps with a shorter last step for any
// remainder; the keystream block then takes one step of BLOCK_BITS rounds once
// the output register is free, and the sequencer returns to idle before the
// next request is taken. The input stalls while a block is in work; a finished
// result waits in the output register while the next request is already being
// processed. Encryption and decryption are the same operation. Key and IV
// registers may be written only while no request is in work.
module kreyvium_ctr_keystream_xor import kcx_pkg::*; #(
  parameter int unsigned BLOCK_BITS    = 46,
  parameter int unsigned WARMUP_ROUNDS = 1152
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [63:0]           counter_i,
  input  logic [BLOCK_BITS-1:0] data_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BLOCK_BITS-1:0] data_out_o
);

  localparam int unsigned RemW = $clog2(WARMUP_ROUNDS + STEP_ROUNDS + 1);

  logic [CFG_W-1:0]      key_high_q, key_low_q, iv_high_q, iv_low_q;
  state_e                state_q, state_d;
  logic [RemW-1:0]       rem_q, rem_d;
  kcx_core_t             core_q, core_d, core_nxt, core_init;
  logic [BLOCK_BITS-1:0] data_q;
  logic                  out_valid_q, out_valid_d;
  logic [BLOCK_BITS-1:0] data_out_q, data_out_d;
  logic [STEP_W-1:0]     step;
  logic [STEP_ROUNDS-1:0] ks_all;
  logic                  in_acc;
  logic                  out_free;
  logic [KEY_BITS-1:0]   key_vec, iv_vec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= IV_HIGH_RST;
      iv_low_q   <= IV_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        REG_IV_HIGH:  iv_high_q  <= cfg_wdata_i;
        REG_IV_LOW:   iv_low_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Initial cipher state: key bits, IV bits, ones, and a trailing zero.
  assign key_vec = {key_high_q, key_low_q};
  assign iv_vec  = {iv_high_q, iv_low_q ^ counter_i};

  always_comb begin
    core_init.key = key_vec;
    core_init.iv  = iv_vec;
    core_init.st  = '0;
    for (int i = 0; i < REG_A_BITS; i++) begin
      core_init.st[i] = key_vec[KEY_BITS-1-i];
    end
    for (int i = 0; i < KEY_BITS; i++) begin
      core_init.st[REG_B_START+i] = iv_vec[KEY_BITS-1-i];
    end
    for (int i = ONES_START; i < STATE_BITS - 1; i++) begin
      core_init.st[i] = 1'b1;
    end
  end

  // Step size: full steps during warm-up with a shorter last step for any remainder, then exactly one block of rounds.
  always_comb begin
    if (state_q == ST_KSTR) begin
      step = STEP_W'(BLOCK_BITS);
    end else if (rem_q >= RemW'(STEP_ROUNDS)) begin
      step = STEP_W'(STEP_ROUNDS);
    end else begin
      step = rem_q[STEP_W-1:0];
    end
  end

  kcx_round_unit u_round (
    .cur_i  (core_q),
    .step_i (step),
    .nxt_o  (core_nxt),
    .ks_o   (ks_all)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    core_d      = core_q;
    out_valid_d = out_valid_q && out_stall_i;
    data_out_d  = data_out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          core_d  = core_init;
          rem_d   = RemW'(WARMUP_ROUNDS);
          state_d = (WARMUP_ROUNDS == 0) ? ST_KSTR : ST_WARM;
        end
      end
      ST_WARM: begin
        core_d = core_nxt;
        rem_d  = rem_q - RemW'(step);
        if (rem_q == RemW'(step)) begin
          state_d = ST_KSTR;
        end
      end
      ST_KSTR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          data_out_d  = data_q ^ ks_all[STEP_ROUNDS-1 -: BLOCK_BITS];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    core_q     <= core_d;
    data_out_q <= data_out_d;
    if (in_acc) begin
      data_q <= data_in_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

  // The sequencer state is always exactly one-hot.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state is not one-hot");

  // An accepted request always starts work.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_WARM || state_q == ST_KSTR))
    else $error("accepted request did not start");

  // Warm-up never runs with no rounds left.
  a_warm_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WARM) |-> (rem_q != '0)) else $error("warm-up with zero rounds left");

  // A new result appears only at the end of a keystream step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_KSTR))
    else $error("result raised outside keystream step");

endmodule
